/* hdl/kds_pkg.sv */
// Shared types and constants for the keypad scan, debounce and hold block.
// No dependencies; imported by every module of the block.
`default_nettype none

package kds_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] REG_CODE_UPPER = 2'd0;
   localparam logic [1:0] REG_CODE_LOWER = 2'd1;
   localparam logic [1:0] REG_HOLD_TIME  = 2'd2;
   localparam logic [1:0] REG_SETTLE     = 2'd3;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   // reset values of the timing registers
   localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;
   localparam logic [7:0]  SETTLE_RESET    = 8'd10;

   // physical matrix size covered by the snapshot and the code tables
   localparam int unsigned MAT_ROWS = 4;
   localparam int unsigned MAT_COLS = 4;

   // queue between front and back
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = 1;
   localparam int unsigned QCNT_W = 2;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_HELD     = 2'd3
   } key_event_type;

   // one classified poll: scanned code and its timestamp
   typedef struct packed {
      logic [7:0]  code;
      logic [31:0] now;
   } kds_item_type;

   // queue status seen by the top level and the back
   typedef struct packed {
      logic not_empty;
      logic not_full;
   } kds_qstat_type;

endpackage

`default_nettype wire

/* hdl/kds_front.sv */
// Front end: holds the code tables and turns each matrix snapshot into a key code.
// Depends on kds_pkg.
`default_nettype none

module kds_front #(
   parameter int unsigned ROWS = 4,
   parameter int unsigned COLS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [kds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kds_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [15:0]                    matrix_closed,
   input  wire logic [31:0]                    now_ms,
   output kds_pkg::kds_item_type               item
);
   import kds_pkg::*;

   localparam int unsigned ScanRows = (ROWS < MAT_ROWS) ? ROWS : MAT_ROWS;
   localparam int unsigned ScanCols = (COLS < MAT_COLS) ? COLS : MAT_COLS;

   logic [63:0]  code_upper_ff, code_upper_in;
   logic [63:0]  code_lower_ff, code_lower_in;
   logic [127:0] code_table;
   logic [7:0]   scan_code;

   // code table register writes
   always_comb begin
      code_upper_in = code_upper_ff;
      code_lower_in = code_lower_ff;
      if (csr_wr_en && (csr_index == REG_CODE_UPPER)) begin
         code_upper_in = csr_wdata;
      end
      if (csr_wr_en && (csr_index == REG_CODE_LOWER)) begin
         code_lower_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_upper_ff <= '0;
         code_lower_ff <= '0;
      end else begin
         code_upper_ff <= code_upper_in;
         code_lower_ff <= code_lower_in;
      end
   end

   assign code_table = {code_lower_ff, code_upper_ff};

   // priority scan: walk backwards so the first closed key (rows, then columns) wins;
   // a closed key whose code is zero still ends the scan
   always_comb begin
      scan_code = 8'd0;
      for (int r = int'(ScanRows) - 1; r >= 0; r--) begin
         for (int c = int'(ScanCols) - 1; c >= 0; c--) begin
            if (matrix_closed[r*4 + c]) begin
               scan_code = code_table[(r*4 + c)*8 +: 8];
            end
         end
      end
   end

   assign item.code = scan_code;
   assign item.now  = now_ms;

endmodule

`default_nettype wire

/* hdl/kds_queue.sv */
// Short word queue between front and back of the keypad block.
// Depends on kds_pkg.
`default_nettype none

module kds_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire kds_pkg::kds_item_type push_item,
   input  wire logic           pop,
   output kds_pkg::kds_item_type pop_item,
   output kds_pkg::kds_qstat_type stat
);
   import kds_pkg::*;

   kds_item_type        mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item       = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.not_full  = (count_ff != QCNT_W'(QDEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue fill count beyond depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> stat.not_empty)
      else $error("queue empty after a push");

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

/* hdl/kds_back.sv */
// Back end: debounce and hold state, event decision and the result register.
// Depends on kds_pkg.
`default_nettype none

module kds_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [kds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kds_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire kds_pkg::kds_qstat_type         qstat,
   input  wire kds_pkg::kds_item_type          q_item,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [7:0]                          rsp_code,
   output kds_pkg::key_event_type              rsp_event
);
   import kds_pkg::*;

   logic [15:0]   hold_time_ff, hold_time_in;
   logic [7:0]    settle_ff, settle_in;
   logic [7:0]    stable_code_ff, stable_code_in;
   logic          settling_ff, settling_in;
   logic [31:0]   settle_start_ff, settle_start_in;
   logic [31:0]   change_time_ff, change_time_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_code_ff, rsp_code_in;
   key_event_type rsp_event_ff, rsp_event_in;

   logic [31:0]   start_eff;
   logic [31:0]   elapsed;
   logic [31:0]   age;
   logic [7:0]    rep_code;
   key_event_type ev;

   // take a word whenever the result register is free or being drained
   assign pop = qstat.not_empty && (!rsp_valid_ff || rsp_ready);

   // timing register writes
   always_comb begin
      hold_time_in = hold_time_ff;
      settle_in    = settle_ff;
      if (csr_wr_en && (csr_index == REG_HOLD_TIME)) begin
         hold_time_in = csr_wdata[15:0];
      end
      if (csr_wr_en && (csr_index == REG_SETTLE)) begin
         settle_in = csr_wdata[7:0];
      end
   end

   // debounce and hold decision for the word at the queue head
   assign start_eff = settling_ff ? settle_start_ff : q_item.now;
   assign elapsed   = q_item.now - start_eff;
   assign age       = q_item.now - change_time_ff;

   always_comb begin
      stable_code_in  = stable_code_ff;
      settling_in     = settling_ff;
      settle_start_in = settle_start_ff;
      change_time_in  = change_time_ff;
      rep_code        = q_item.code;
      ev              = EV_NONE;
      if (q_item.code != stable_code_ff) begin
         change_time_in = q_item.now;
         if (!settling_ff) begin
            settle_start_in = q_item.now;
            settling_in     = 1'b1;
         end
         priority if (elapsed < {24'd0, settle_ff}) begin
            rep_code = stable_code_ff;
            ev       = EV_NONE;
         end else if (q_item.code == 8'd0) begin
            rep_code       = stable_code_ff;
            ev             = EV_RELEASED;
            stable_code_in = 8'd0;
            settling_in    = 1'b0;
         end else begin
            rep_code       = q_item.code;
            ev             = EV_PRESSED;
            stable_code_in = q_item.code;
            settling_in    = 1'b0;
         end
      end else if ((q_item.code != 8'd0) && (age >= {16'd0, hold_time_ff})) begin
         ev = EV_HELD;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_code_in  = pop ? rep_code : rsp_code_ff;
      rsp_event_in = pop ? ev : rsp_event_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff    <= HOLD_TIME_RESET;
         settle_ff       <= SETTLE_RESET;
         stable_code_ff  <= '0;
         settling_ff     <= 1'b0;
         settle_start_ff <= '0;
         change_time_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         hold_time_ff <= hold_time_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            stable_code_ff  <= stable_code_in;
            settling_ff     <= settling_in;
            settle_start_ff <= settle_start_in;
            change_time_ff  <= change_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff  <= rsp_code_in;
      rsp_event_ff <= rsp_event_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = rsp_code_ff;
   assign rsp_event = rsp_event_ff;

   a_release_has_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == EV_RELEASED) |-> rsp_code_ff != 8'd0)
      else $error("release reported without a key");

   a_press_updates: assert property (@(posedge clock) disable iff (reset)
      pop && (ev == EV_PRESSED) |=> stable_code_ff == $past(q_item.code) && !settling_ff)
      else $error("press did not latch the stable key");

   a_window_silent: assert property (@(posedge clock) disable iff (reset)
      pop && settling_ff && (q_item.code != stable_code_ff)
         && (elapsed < {24'd0, settle_ff}) |-> ev == EV_NONE)
      else $error("event reported inside debounce window");

endmodule

`default_nettype wire

/* hdl/keypad_scan_debounce_hold.sv */
// Keypad poll block: 4x4 matrix scan, debounce window and hold detection.
// req_ words are polls (matrix snapshot plus millisecond time), one result word
// per poll leaves on rsp_. The csr_ port writes the code tables and timings.
// Path: a poll is written into the queue, then its decision is registered in the
// result register when the receiver is ready.
// Throughput: one poll per cycle while rsp_tready is high; the front is a combinational
// priority scan and the back two subtract-and-compare pairs, both combinational.
// A two-word queue sits between front and back; when rsp_tready is low the
// result register holds, the queue fills and req_tready drops once it is full.
// Reset (synchronous) empties the queue and result register, clears the stable
// key and debounce state, zeroes the code tables and loads hold 1000 ms and
// settle 10 ms. Since codes reset to zero, load nonzero codes before polling.
// Write configuration only while no poll is in flight.
// Depends on kds_pkg, kds_front, kds_queue and kds_back.
`default_nettype none

module keypad_scan_debounce_hold #(
   parameter int unsigned ROWS = 4,
   parameter int unsigned COLS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_wr_en,
   input  wire logic [kds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kds_pkg::CSR_DATA_W-1:0] csr_wdata,
   // polls
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [47:0]                    req_tdata,  // matrix_closed[15:0], now_ms[47:16]
   // results
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata   // key_code[7:0], key_event[9:8], zero
);
   import kds_pkg::*;

   kds_item_type  front_item;
   kds_item_type  q_item;
   kds_qstat_type qstat;
   logic          push;
   logic          pop;
   logic [7:0]    rsp_code;
   key_event_type rsp_event;

   assign req_tready = qstat.not_full;
   assign push       = req_tvalid && qstat.not_full;

   kds_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .matrix_closed (req_tdata[15:0]),
      .now_ms        (req_tdata[47:16]),
      .item          (front_item)
   );

   kds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (q_item),
      .stat      (qstat)
   );

   kds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .q_item    (q_item),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_code  (rsp_code),
      .rsp_event (rsp_event)
   );

   assign rsp_tdata = {6'd0, rsp_event, rsp_code};

endmodule

`default_nettype wire
